// ----- hw/rtl/wspd_pkg.sv -----
// ----------------------------------------------------------------------------
// wspd_pkg - weather sensor packet decoder package
// Constants, status codes, result layout and the CRC and UV helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package wspd_pkg;

    localparam int PACKET_BYTES = 17;
    localparam int CNT_W        = 5;
    localparam int UV_STEPS     = 13;

    localparam logic [7:0]  FAMILY_CODE   = 8'h24;
    localparam logic [7:0]  CRC_POLY      = 8'h31;
    localparam logic [10:0] TEMP_NONE     = 11'h7ff;
    localparam logic [11:0] TEMP_OFFSET   = 12'd400;
    localparam logic [7:0]  BYTE_NONE     = 8'hff;
    localparam logic [8:0]  NINE_NONE     = 9'h1ff;
    localparam logic [15:0] UV_NONE       = 16'hffff;
    localparam logic [23:0] LIGHT_NONE    = 24'hffffff;

    localparam logic [15:0] WIND_SCALE_RST  = 16'd8356;
    localparam logic [15:0] RAIN_CUP_RST    = 16'd16646;

    // register indexes on the APB port
    localparam logic REG_WIND_SCALE  = 1'b0;
    localparam logic REG_RAIN_CUP    = 1'b1;

    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SHORT  = 3'd1;
    localparam logic [2:0] ST_FAMILY = 3'd2;
    localparam logic [2:0] ST_CRC    = 3'd3;
    localparam logic [2:0] ST_SUM    = 3'd4;

    // presence bits
    localparam int PR_TEMP  = 0;
    localparam int PR_HUM   = 1;
    localparam int PR_DIR   = 2;
    localparam int PR_AVG   = 3;
    localparam int PR_GUST  = 4;
    localparam int PR_RAIN  = 5;
    localparam int PR_UV    = 6;
    localparam int PR_LIGHT = 7;

    localparam int RESULT_W = 160;

    typedef struct packed {
        logic [4:0]  pad;
        logic [23:0] light_tenths_lux;
        logic [3:0]  uv_index;
        logic [31:0] rain_total;
        logic [23:0] wind_gust;
        logic [21:0] wind_avg;
        logic [8:0]  wind_heading;
        logic [7:0]  humidity;
        logic signed [11:0] temp_tenths;
        logic [7:0]  present;
        logic        battery_low;
        logic [7:0]  sensor_id;
        logic [2:0]  status;
    } result_t;

    function automatic logic [15:0] uv_limit(input int idx);
        logic [15:0] lim;
        case (idx)
            0:       lim = 16'd432;
            1:       lim = 16'd851;
            2:       lim = 16'd1210;
            3:       lim = 16'd1570;
            4:       lim = 16'd2017;
            5:       lim = 16'd2450;
            6:       lim = 16'd2761;
            7:       lim = 16'd3100;
            8:       lim = 16'd3512;
            9:       lim = 16'd3918;
            10:      lim = 16'd4277;
            11:      lim = 16'd4650;
            default: lim = 16'd5029;
        endcase
        return lim;
    endfunction

    // number of thresholds strictly below the reading
    function automatic logic [3:0] uv_level(input logic [15:0] raw);
        logic [3:0] lvl;
        lvl = 4'd0;
        for (int i = 0; i < UV_STEPS; i++) begin
            if (uv_limit(i) < raw) begin
                lvl = lvl + 4'd1;
            end
        end
        return lvl;
    endfunction

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/weather_sensor_packet_decoder_top.sv -----
// ----------------------------------------------------------------------------
// weather_sensor_packet_decoder_top - weather station packet decoder
// Collects a 17-byte packet, checks length, family, CRC-8 and sum, and
// returns one decoded reading set per packet.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | one packet byte per item, tlast on the final byte
//  m_*      | out       | one result item per packet (status and readings)
//  apb      | in        | anemometer scale at 0x0, rain_cup_size at 0x4
//
// Takes one byte per cycle while s_tready is high; the per-byte CRC and sum
// update sets that rate. A result passes one decode stage, then the output
// register. Reset (aresetn low, synchronous) clears the byte count,
// accumulators and valid flags. s_tready drops only while a decoded packet
// waits behind a result that has not been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module weather_sensor_packet_decoder_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,    // [7:0] data_byte
    input  wire logic         s_tlast,    // last_byte
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [159:0]      m_tdata,    // status[2:0], sensor_id[10:3],
                                          // battery_low[11], present[19:12],
                                          // temp_tenths[31:20], humidity[39:32],
                                          // wind_heading[48:40], wind_avg[70:49],
                                          // wind_gust[94:71], rain_total[126:95],
                                          // uv_index[130:127],
                                          // light_tenths_lux[154:131], zeros above
    // configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0] anemo_scale_reg;
    logic [15:0] rain_cup_reg;

    logic [wspd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] store_reg [wspd_pkg::PACKET_BYTES];

    logic       pend_reg, pend_next;
    logic [7:0] crc_fin_reg;
    logic [7:0] sum_fin_reg;
    logic       short_reg;

    logic       m_valid_reg, m_valid_next;
    wspd_pkg::result_t res_reg, res_next;

    logic       s_acc;
    logic       adv;
    logic       cfg_wr;
    logic [7:0] crc_upd;
    logic [7:0] sum_upd;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            anemo_scale_reg <= wspd_pkg::WIND_SCALE_RST;
            rain_cup_reg    <= wspd_pkg::RAIN_CUP_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == wspd_pkg::REG_WIND_SCALE) begin
                anemo_scale_reg <= pwdata[15:0];
            end else begin
                rain_cup_reg <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == wspd_pkg::REG_WIND_SCALE) begin
            prdata = {16'd0, anemo_scale_reg};
        end else begin
            prdata = {16'd0, rain_cup_reg};
        end
    end

    // ------------------------------------------------------------------
    // byte intake
    // ------------------------------------------------------------------
    assign adv      = pend_reg && (!m_valid_reg || m_tready);
    assign s_tready = !pend_reg || adv;
    assign s_acc    = s_tvalid && s_tready;

    assign crc_upd = (cnt_reg < 5'd15) ? wspd_pkg::crc8_byte(crc_reg, s_tdata) : crc_reg;
    assign sum_upd = (cnt_reg < 5'd16) ? sum_reg + s_tdata : sum_reg;

    always_comb begin
        cnt_next = cnt_reg;
        crc_next = crc_reg;
        sum_next = sum_reg;
        if (s_acc) begin
            if (s_tlast) begin
                cnt_next = '0;
                crc_next = '0;
                sum_next = '0;
            end else begin
                if (cnt_reg != '1) begin
                    cnt_next = cnt_reg + 5'd1;
                end
                crc_next = crc_upd;
                sum_next = sum_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            crc_reg <= '0;
            sum_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            crc_reg <= crc_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < wspd_pkg::PACKET_BYTES; i++) begin
            if (s_acc && cnt_reg == wspd_pkg::CNT_W'(i)) begin
                store_reg[i] <= s_tdata;
            end
        end
    end

    // snapshot of the finished packet's checks
    always_ff @(posedge aclk) begin
        if (s_acc && s_tlast) begin
            crc_fin_reg <= crc_upd;
            sum_fin_reg <= sum_upd;
            short_reg   <= (cnt_reg < 5'd16);
        end
    end

    always_comb begin
        pend_next = pend_reg;
        if (s_acc && s_tlast) begin
            pend_next = 1'b1;
        end else if (adv) begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // ------------------------------------------------------------------
    // decode
    // ------------------------------------------------------------------
    logic [2:0]  status;
    logic [10:0] temp_code;
    logic [8:0]  dir_raw;
    logic [8:0]  avg_raw;
    logic [15:0] rain_count;
    logic [15:0] uv_raw;
    logic [23:0] lux_code;
    logic [24:0] avg_prod;
    logic [23:0] gust_prod;
    logic [31:0] rain_prod;

    assign temp_code  = {store_reg[3][2:0], store_reg[4]};
    assign dir_raw    = {store_reg[3][7], store_reg[2]};
    assign avg_raw    = {store_reg[3][4], store_reg[6]};
    assign rain_count = {store_reg[8], store_reg[9]};
    assign uv_raw     = {store_reg[10], store_reg[11]};
    assign lux_code   = {store_reg[12], store_reg[13], store_reg[14]};

    assign avg_prod  = avg_raw * anemo_scale_reg;
    assign gust_prod = store_reg[7] * anemo_scale_reg;
    assign rain_prod = rain_count * rain_cup_reg;

    always_comb begin
        if (short_reg) begin
            status = wspd_pkg::ST_SHORT;
        end else if (store_reg[0] != wspd_pkg::FAMILY_CODE) begin
            status = wspd_pkg::ST_FAMILY;
        end else if (crc_fin_reg != store_reg[15]) begin
            status = wspd_pkg::ST_CRC;
        end else if (sum_fin_reg != store_reg[16]) begin
            status = wspd_pkg::ST_SUM;
        end else begin
            status = wspd_pkg::ST_OK;
        end
    end

    always_comb begin
        res_next        = '0;
        res_next.status = status;
        if (status == wspd_pkg::ST_OK) begin
            res_next.sensor_id   = store_reg[1];
            res_next.battery_low = store_reg[3][3];
            if (temp_code != wspd_pkg::TEMP_NONE) begin
                res_next.temp_tenths = {1'b0, temp_code} - wspd_pkg::TEMP_OFFSET;
                res_next.present[wspd_pkg::PR_TEMP] = 1'b1;
            end
            if (store_reg[5] != wspd_pkg::BYTE_NONE) begin
                res_next.humidity = store_reg[5];
                res_next.present[wspd_pkg::PR_HUM] = 1'b1;
            end
            if (dir_raw != wspd_pkg::NINE_NONE) begin
                res_next.wind_heading = dir_raw;
                res_next.present[wspd_pkg::PR_DIR] = 1'b1;
            end
            if (avg_raw != wspd_pkg::NINE_NONE) begin
                res_next.wind_avg = avg_prod[24:3];
                res_next.present[wspd_pkg::PR_AVG] = 1'b1;
            end
            if (store_reg[7] != wspd_pkg::BYTE_NONE) begin
                res_next.wind_gust = gust_prod;
                res_next.present[wspd_pkg::PR_GUST] = 1'b1;
            end
            res_next.rain_total = rain_prod;
            res_next.present[wspd_pkg::PR_RAIN] = 1'b1;
            if (uv_raw != wspd_pkg::UV_NONE) begin
                res_next.uv_index = wspd_pkg::uv_level(uv_raw);
                res_next.present[wspd_pkg::PR_UV] = 1'b1;
                if (lux_code != wspd_pkg::LIGHT_NONE) begin
                    res_next.light_tenths_lux = lux_code;
                    res_next.present[wspd_pkg::PR_LIGHT] = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (adv) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = res_reg;

`ifndef SYNTHESIS
    a_hold_intake: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("byte taken while a decoded packet is held");

    a_last_pends: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (pend_reg && cnt_reg == '0))
        else $error("last byte did not start a decode");

    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] != wspd_pkg::ST_OK) |-> (m_tdata[154:3] == '0))
        else $error("failed packet carries readings");

    a_ok_rain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] == wspd_pkg::ST_OK) |-> m_tdata[12 + wspd_pkg::PR_RAIN])
        else $error("good packet without rain presence");
`endif

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb - weather sensor packet decoder testbench
// Streams packet bytes into the decoder and predicts each packet's status
// and decoded readings from the bytes accepted. A short directed set covers
// sentinels, field extremes, UV thresholds and every status. Then random
// packets follow under several wind and rain scalings. Both stream sides
// idle at random, and the result side holds off long enough to stall input.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 190;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES = 400;
    localparam logic [16*wspd_pkg::UV_STEPS-1:0] UV_EDGES = {
        16'd5029, 16'd4650, 16'd4277, 16'd3918, 16'd3512, 16'd3100, 16'd2761,
        16'd2450, 16'd2017, 16'd1570, 16'd1210, 16'd851, 16'd432
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;    // [7:0] data_byte
    logic         s_tlast = 1'b0;     // last_byte
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;            // status, sensor_id, battery_low, present,
                                      // temp, humidity, dir, avg, gust, rain,
                                      // uv_index, light, zeros above
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = 3'd0;
    logic [31:0]  pwdata = 32'h0;
    logic [31:0]  prdata;
    logic         pready;

    byte_item_t          pending_bytes[$];
    wspd_pkg::result_t   readings_q[$];
    byte_item_t took;
    logic       s_taken = 1'b0;
    logic       quiet = 1'b0;
    int         hold_off = 0;
    int         mismatches = 0;
    int         cycles = 0;
    int         phase_bytes = 0;
    logic [7:0] pkt [0:47];

    // predictor state
    logic [4:0]  seen_cnt = 5'd0;
    logic [7:0]  store [0:wspd_pkg::PACKET_BYTES-1];
    logic [7:0]  crc_run = 8'h00;
    logic [7:0]  sum_run = 8'h00;
    logic [15:0] wind_cfg = 16'd8356;
    logic [15:0] rain_cfg = 16'd16646;

    weather_sensor_packet_decoder_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic take_break();
        return !quiet && ($urandom_range(99) < 12);
    endfunction

    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] d);
        logic [7:0] r;
        r = acc ^ d;
        for (int k = 0; k < 8; k++) begin
            r = r[7] ? ({r[6:0], 1'b0} ^ wspd_pkg::CRC_POLY) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    // fold one accepted byte into the running packet; decode on the last one
    task automatic absorb_byte(input logic [7:0] d, input logic last);
        wspd_pkg::result_t r;
        logic [10:0] traw;
        logic [8:0]  dir_raw;
        logic [8:0]  avg_raw;
        logic [15:0] uv_raw;
        logic [23:0] lux_code;
        logic [31:0] prod;
        if (seen_cnt < wspd_pkg::PACKET_BYTES) begin
            store[seen_cnt] = d;
        end
        if (seen_cnt < 15) begin
            crc_run = crc8_step(crc_run, d);
        end
        if (seen_cnt < 16) begin
            sum_run = sum_run + d;
        end
        if (seen_cnt != 5'd31) begin
            seen_cnt = seen_cnt + 5'd1;
        end
        if (last) begin
            r = '0;
            if (seen_cnt < wspd_pkg::PACKET_BYTES) begin
                r.status = wspd_pkg::ST_SHORT;
            end else if (store[0] != wspd_pkg::FAMILY_CODE) begin
                r.status = wspd_pkg::ST_FAMILY;
            end else if (crc_run != store[15]) begin
                r.status = wspd_pkg::ST_CRC;
            end else if (sum_run != store[16]) begin
                r.status = wspd_pkg::ST_SUM;
            end else begin
                r.status = wspd_pkg::ST_OK;
                r.sensor_id = store[1];
                r.battery_low = store[3][3];
                traw = {store[3][2:0], store[4]};
                if (traw != wspd_pkg::TEMP_NONE) begin
                    r.temp_tenths = {1'b0, traw} - wspd_pkg::TEMP_OFFSET;
                    r.present[wspd_pkg::PR_TEMP] = 1'b1;
                end
                if (store[5] != wspd_pkg::BYTE_NONE) begin
                    r.humidity = store[5];
                    r.present[wspd_pkg::PR_HUM] = 1'b1;
                end
                dir_raw = {store[3][7], store[2]};
                if (dir_raw != wspd_pkg::NINE_NONE) begin
                    r.wind_heading = dir_raw;
                    r.present[wspd_pkg::PR_DIR] = 1'b1;
                end
                avg_raw = {store[3][4], store[6]};
                if (avg_raw != wspd_pkg::NINE_NONE) begin
                    prod = 32'(avg_raw) * 32'(wind_cfg);
                    r.wind_avg = prod[24:3];
                    r.present[wspd_pkg::PR_AVG] = 1'b1;
                end
                if (store[7] != wspd_pkg::BYTE_NONE) begin
                    prod = 32'(store[7]) * 32'(wind_cfg);
                    r.wind_gust = prod[23:0];
                    r.present[wspd_pkg::PR_GUST] = 1'b1;
                end
                r.rain_total = 32'({store[8], store[9]}) * 32'(rain_cfg);
                r.present[wspd_pkg::PR_RAIN] = 1'b1;
                uv_raw = {store[10], store[11]};
                if (uv_raw != wspd_pkg::UV_NONE) begin
                    for (int k = 0; k < wspd_pkg::UV_STEPS; k++) begin
                        if (UV_EDGES[k*16 +: 16] < uv_raw) begin
                            r.uv_index = r.uv_index + 4'd1;
                        end
                    end
                    r.present[wspd_pkg::PR_UV] = 1'b1;
                    lux_code = {store[12], store[13], store[14]};
                    if (lux_code != wspd_pkg::LIGHT_NONE) begin
                        r.light_tenths_lux = lux_code;
                        r.present[wspd_pkg::PR_LIGHT] = 1'b1;
                    end
                end
            end
            readings_q.push_back(r);
            seen_cnt = 5'd0;
            crc_run = 8'h00;
            sum_run = 8'h00;
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void compare_reading(wspd_pkg::result_t want, wspd_pkg::result_t got);
        check_field("status", want.status, got.status);
        check_field("sensor_id", want.sensor_id, got.sensor_id);
        check_field("battery_low", want.battery_low, got.battery_low);
        check_field("present", want.present, got.present);
        check_field("temp_tenths", 32'(want.temp_tenths), 32'(got.temp_tenths));
        check_field("humidity", want.humidity, got.humidity);
        check_field("wind_heading", want.wind_heading, got.wind_heading);
        check_field("wind_avg", want.wind_avg, got.wind_avg);
        check_field("wind_gust", want.wind_gust, got.wind_gust);
        check_field("rain_total", want.rain_total, got.rain_total);
        check_field("uv_index", want.uv_index, got.uv_index);
        check_field("light_tenths_lux", want.light_tenths_lux, got.light_tenths_lux);
        check_field("pad", want.pad, got.pad);
    endfunction

    // offer the front byte; advance only after a handshake
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (pending_bytes.size() != 0 && !take_break()) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_bytes[0].data;
                s_tlast  <= pending_bytes[0].last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off = hold_off - 1;
        end else begin
            m_tready <= !take_break();
        end
    end

    always @(posedge aclk) begin
        s_taken = aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (readings_q.size() == 0) begin
                $error("result item with no packet pending: 0x%0h", m_tdata);
                mismatches++;
            end else begin
                compare_reading(readings_q.pop_front(), wspd_pkg::result_t'(m_tdata));
            end
        end
        if (s_taken) begin
            took = pending_bytes.pop_front();
            absorb_byte(took.data, took.last);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic reg_write(input logic idx, input logic [15:0] val);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {16'($urandom), val};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == wspd_pkg::REG_WIND_SCALE) begin
            wind_cfg = val;
        end else begin
            rain_cfg = val;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic settle();
        while (pending_bytes.size() != 0 || s_tvalid || readings_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_readings(input logic [7:0] id, input logic batt,
                                input logic [10:0] temp, input logic [7:0] hum,
                                input logic [8:0] dir, input logic [8:0] avg,
                                input logic [7:0] gust, input logic [15:0] rain,
                                input logic [15:0] uv, input logic [23:0] light);
        logic [1:0] spare;
        spare   = 2'($urandom);
        pkt[1]  = id;
        pkt[2]  = dir[7:0];
        pkt[3]  = {dir[8], spare, avg[8], batt, temp[10:8]};
        pkt[4]  = temp[7:0];
        pkt[5]  = hum;
        pkt[6]  = avg[7:0];
        pkt[7]  = gust;
        pkt[8]  = rain[15:8];
        pkt[9]  = rain[7:0];
        pkt[10] = uv[15:8];
        pkt[11] = uv[7:0];
        pkt[12] = light[23:16];
        pkt[13] = light[15:8];
        pkt[14] = light[7:0];
    endtask

    // random readings, each sentinel hit about one time in eight
    task automatic random_readings();
        logic [10:0] temp;
        logic [7:0]  hum;
        logic [8:0]  dir;
        logic [8:0]  avg;
        logic [7:0]  gust;
        logic [15:0] uv;
        logic [23:0] light;
        int          pick;
        temp  = ($urandom_range(7) == 0) ? wspd_pkg::TEMP_NONE : 11'($urandom);
        hum   = ($urandom_range(7) == 0) ? wspd_pkg::BYTE_NONE : 8'($urandom);
        dir   = ($urandom_range(7) == 0) ? wspd_pkg::NINE_NONE : 9'($urandom);
        avg   = ($urandom_range(7) == 0) ? wspd_pkg::NINE_NONE : 9'($urandom);
        gust  = ($urandom_range(7) == 0) ? wspd_pkg::BYTE_NONE : 8'($urandom);
        light = ($urandom_range(7) == 0) ? wspd_pkg::LIGHT_NONE : 24'($urandom);
        pick  = $urandom_range(7);
        if (pick == 0) begin
            uv = wspd_pkg::UV_NONE;
        end else if (pick < 4) begin
            // land on or next to a threshold
            uv = UV_EDGES[$urandom_range(wspd_pkg::UV_STEPS-1)*16 +: 16]
                 + 16'($urandom_range(2)) - 16'd1;
        end else if (pick < 6) begin
            uv = 16'($urandom_range(6000));
        end else begin
            uv = 16'($urandom);
        end
        set_readings(8'($urandom), 1'($urandom), temp, hum, dir, avg, gust,
                     16'($urandom), uv, light);
    endtask

    task automatic seal_packet();
        logic [7:0] c;
        logic [7:0] s;
        c = 8'h00;
        s = 8'h00;
        pkt[0] = wspd_pkg::FAMILY_CODE;
        for (int i = 0; i < 15; i++) begin
            c = crc8_step(c, pkt[i]);
        end
        pkt[15] = c;
        for (int i = 0; i < 16; i++) begin
            s = s + pkt[i];
        end
        pkt[16] = s;
    endtask

    task automatic queue_packet(input int len);
        byte_item_t it;
        for (int i = 0; i < len; i++) begin
            it.data = pkt[i];
            it.last = (i == len - 1);
            pending_bytes.push_back(it);
        end
        phase_bytes += len;
    endtask

    // mostly well-formed packets, the rest truncated, corrupted or overlong
    task automatic random_packet();
        int kind;
        int len;
        random_readings();
        seal_packet();
        len  = wspd_pkg::PACKET_BYTES;
        kind = $urandom_range(99);
        if (kind < 70) begin
            len = wspd_pkg::PACKET_BYTES;
        end else if (kind < 76) begin
            len = $urandom_range(1, wspd_pkg::PACKET_BYTES - 1);
        end else if (kind < 82) begin
            pkt[0] = 8'($urandom);
            if (pkt[0] == wspd_pkg::FAMILY_CODE) begin
                pkt[0] = ~pkt[0];
            end
        end else if (kind < 88) begin
            pkt[15] = pkt[15] ^ 8'($urandom_range(1, 255));
        end else if (kind < 94) begin
            pkt[16] = pkt[16] ^ 8'($urandom_range(1, 255));
        end else begin
            len = $urandom_range(wspd_pkg::PACKET_BYTES + 1, 45);
            for (int i = wspd_pkg::PACKET_BYTES; i < len; i++) begin
                pkt[i] = 8'($urandom);
            end
        end
        queue_packet(len);
    endtask

    task automatic random_phase();
        phase_bytes = 0;
        while (phase_bytes < PHASE_BYTES) begin
            random_packet();
        end
        settle();
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // directed packets under the reset scalings
        set_readings(8'h00, 1'b0, wspd_pkg::TEMP_NONE, wspd_pkg::BYTE_NONE,
                     wspd_pkg::NINE_NONE, wspd_pkg::NINE_NONE,
                     wspd_pkg::BYTE_NONE, 16'h0000, wspd_pkg::UV_NONE, 24'h000000);
        seal_packet();
        queue_packet(wspd_pkg::PACKET_BYTES);
        set_readings(8'hff, 1'b1, 11'h000, 8'h00, 9'h000, 9'h000, 8'h00,
                     16'hffff, 16'h0000, 24'h000000);
        seal_packet();
        queue_packet(wspd_pkg::PACKET_BYTES);
        set_readings(8'h5a, 1'b0, 11'h7fe, 8'hfe, 9'h1fe, 9'h1fe, 8'hfe,
                     16'hffff, 16'd5030, 24'hfffffe);
        seal_packet();
        queue_packet(wspd_pkg::PACKET_BYTES);
        set_readings(8'h11, 1'b1, 11'h190, 8'd50, 9'd180, 9'd12, 8'd30,
                     16'd7, 16'd432, wspd_pkg::LIGHT_NONE);
        seal_packet();
        queue_packet(wspd_pkg::PACKET_BYTES);
        set_readings(8'h22, 1'b0, 11'h3ff, 8'd99, 9'd359, 9'd255, 8'd128,
                     16'd4096, 16'd433, 24'h000001);
        seal_packet();
        queue_packet(wspd_pkg::PACKET_BYTES);
        set_readings(8'h33, 1'b1, 11'h400, 8'd1, 9'd256, 9'd256, 8'd1,
                     16'd1, 16'd5029, 24'h800000);
        seal_packet();
        queue_packet(wspd_pkg::PACKET_BYTES);
        pkt[0] = wspd_pkg::FAMILY_CODE;
        queue_packet(1);
        random_readings();
        seal_packet();
        queue_packet(wspd_pkg::PACKET_BYTES - 1);
        seal_packet();
        pkt[0] = wspd_pkg::FAMILY_CODE + 8'd1;
        queue_packet(wspd_pkg::PACKET_BYTES);
        seal_packet();
        pkt[15] = ~pkt[15];
        queue_packet(wspd_pkg::PACKET_BYTES);
        seal_packet();
        pkt[16] = pkt[16] + 8'd1;
        queue_packet(wspd_pkg::PACKET_BYTES);
        random_readings();
        seal_packet();
        pkt[17] = 8'($urandom);
        queue_packet(wspd_pkg::PACKET_BYTES + 1);
        random_readings();
        seal_packet();
        for (int i = wspd_pkg::PACKET_BYTES; i < 40; i++) begin
            pkt[i] = 8'($urandom);
        end
        queue_packet(40);
        settle();

        reg_write(wspd_pkg::REG_WIND_SCALE, 16'hffff);
        reg_write(wspd_pkg::REG_RAIN_CUP, 16'hffff);
        random_phase();

        // stall the result side so the decoder backs up into the input
        reg_write(wspd_pkg::REG_WIND_SCALE, 16'h0000);
        reg_write(wspd_pkg::REG_RAIN_CUP, 16'h0000);
        hold_off = HOLD_CYCLES;
        random_phase();

        // no idling on either side
        reg_write(wspd_pkg::REG_WIND_SCALE, 16'd18350);
        reg_write(wspd_pkg::REG_RAIN_CUP, 16'($urandom));
        quiet = 1'b1;
        random_phase();
        quiet = 1'b0;

        reg_write(wspd_pkg::REG_WIND_SCALE, 16'($urandom));
        reg_write(wspd_pkg::REG_RAIN_CUP, 16'($urandom));
        random_phase();

        if (mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/wspd_pkg.sv
hw/rtl/weather_sensor_packet_decoder_top.sv
verif/tb.sv
